@@ src/ttm_pkg.sv @@
// Shared types, constants and helper functions of the time-division tone multiplexer.
// Used by ttm_ctrl, ttm_datapath and tdm_tone_channel_multiplexer; depends on nothing.
package ttm_pkg;

    localparam int CHANNELS_DEF = 4;

    localparam int CMD_W  = 3;
    localparam int CHAN_W = 3;
    localparam int FREQ_W = 16;
    localparam int DL_W   = 16;
    localparam int PID_W  = 16;
    localparam int SLOT_W = 8;
    localparam int TICK_W = 32;
    localparam int STAT_W = 32;
    localparam int ACT_W  = 2;
    localparam int PLAY_W = 4;

    localparam logic [SLOT_W-1:0] SLOT_RESET = 8'd20;
    localparam logic [FREQ_W-1:0] LFSR_SEED  = 16'hACE1;
    localparam logic [FREQ_W-1:0] LFSR_TAPS  = 16'hB400;
    localparam logic [FREQ_W-1:0] NOISE_MASK = 16'h0FFF;
    localparam logic [FREQ_W-1:0] NOISE_BASE = 16'd1000;

    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STAT_CLR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TONE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic tick;
        logic scan;
        logic check;
        logic apply;
        logic clr_stats;
        logic read;
        logic emit;
        logic idx_clr;
        logic idx_inc;
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ch_ok;
        logic             pid_match;
        logic             slot_nz;
        logic             scan_hit;
        logic             last_idx;
    } t_status;

    // One step of the Galois noise register; the bit shifted out selects the taps.
    function automatic logic [FREQ_W-1:0] lfsr_next(input logic [FREQ_W-1:0] cur);
        logic [FREQ_W-1:0] sh;
        sh = cur >> 1;
        return cur[0] ? (sh ^ LFSR_TAPS) : sh;
    endfunction

endpackage

@@ src/ttm_ctrl.sv @@
// Sequencing state machine of the tone multiplexer: handshakes and step order.
// Depends on ttm_pkg for the command and status structs and command codes.
module ttm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  ttm_pkg::t_status  i_status,
    output ttm_pkg::t_ctrl    o_ctrl
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_APPLY  = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    logic           r_out_valid, n_out_valid;
    ttm_pkg::t_ctrl ctl;

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    ctl.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESULT;
                unique case (i_status.cmd)
                    ttm_pkg::CMD_TICK: begin
                        ctl.tick    = 1'b1;
                        ctl.idx_clr = 1'b1;
                        if (!i_status.slot_nz) begin
                            n_state = S_SCAN;
                        end
                    end
                    ttm_pkg::CMD_NOTE: begin
                        if (i_status.ch_ok) begin
                            n_state = S_CHECK;
                        end
                    end
                    ttm_pkg::CMD_STAT_CLR: begin
                        ctl.clr_stats = 1'b1;
                    end
                    ttm_pkg::CMD_EXIT: begin
                        if (i_status.pid_match) begin
                            ctl.idx_clr = 1'b1;
                            n_state     = S_CHECK;
                        end
                    end
                    ttm_pkg::CMD_READ: begin
                        ctl.read = 1'b1;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_SCAN: begin
                // One channel is tried per cycle, starting at the rotor.
                ctl.scan = 1'b1;
                if (i_status.scan_hit || i_status.last_idx) begin
                    n_state = S_RESULT;
                end else begin
                    ctl.idx_inc = 1'b1;
                end
            end
            S_CHECK: begin
                ctl.check = 1'b1;
                n_state   = S_APPLY;
            end
            S_APPLY: begin
                ctl.apply = 1'b1;
                if (i_status.cmd == ttm_pkg::CMD_EXIT && !i_status.last_idx) begin
                    ctl.idx_inc = 1'b1;
                    n_state     = S_CHECK;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    ctl.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (ctl.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ctrl      = ctl;

    // Only one word is in flight: an accepted word blocks the input until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a word is still being processed");

    // The channel scan gives up after trying every channel once.
    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_status.last_idx) |=> (r_state == S_RESULT))
        else $error("channel scan ran past the last channel");

    // A new result appears only out of the result state.
    a_out_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESULT))
        else $error("output word raised outside the result state");

endmodule

@@ src/ttm_datapath.sv @@
// Datapath of the tone multiplexer: channel table, slot timer, noise register,
// glitch statistics and the result and output registers. Depends on ttm_pkg.
module ttm_datapath #(
    parameter int CHANNELS = ttm_pkg::CHANNELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttm_pkg::t_ctrl               i_ctrl,
    output ttm_pkg::t_status             o_status,
    input  logic                         i_cfg_we,
    input  logic [ttm_pkg::SLOT_W-1:0]   i_cfg_data,
    input  logic [ttm_pkg::CMD_W-1:0]    i_cmd,
    input  logic [ttm_pkg::CHAN_W-1:0]   i_channel,
    input  logic [ttm_pkg::FREQ_W-1:0]   i_freq_hz,
    input  logic [ttm_pkg::DL_W-1:0]     i_deadline_ms,
    input  logic [ttm_pkg::PID_W-1:0]    i_task_pid,
    output logic [ttm_pkg::ACT_W-1:0]    o_action,
    output logic [ttm_pkg::FREQ_W-1:0]   o_tone_hz,
    output logic [ttm_pkg::PLAY_W-1:0]   o_playing_channel,
    output logic [ttm_pkg::STAT_W-1:0]   o_glitch_total,
    output logic [ttm_pkg::STAT_W-1:0]   o_glitch_delay_sum
);

    localparam int CW = $clog2(CHANNELS);
    localparam int EW = CW + ttm_pkg::CHAN_W;
    localparam logic [CW-1:0] LAST = CW'(CHANNELS - 1);

    // Accepted word.
    logic [ttm_pkg::CMD_W-1:0]  r_cmd;
    logic [ttm_pkg::CHAN_W-1:0] r_channel;
    logic [ttm_pkg::FREQ_W-1:0] r_freq;
    logic [ttm_pkg::DL_W-1:0]   r_dl;
    logic [ttm_pkg::PID_W-1:0]  r_pid;

    // Channel table.
    logic [ttm_pkg::FREQ_W-1:0] r_chan_freq     [CHANNELS];
    logic                       r_chan_active   [CHANNELS];
    logic [ttm_pkg::TICK_W-1:0] r_chan_deadline [CHANNELS];
    logic                       r_chan_dl_valid [CHANNELS];
    logic [ttm_pkg::STAT_W-1:0] r_chan_glitches [CHANNELS];
    logic [ttm_pkg::STAT_W-1:0] r_chan_delay    [CHANNELS];

    logic [CW-1:0]              r_rotor;
    logic [CW-1:0]              r_current;
    logic [CW-1:0]              r_idx;
    logic [ttm_pkg::SLOT_W-1:0] r_slot_left;
    logic [ttm_pkg::SLOT_W-1:0] r_slot_length;
    logic [ttm_pkg::FREQ_W-1:0] r_lfsr;
    logic [ttm_pkg::TICK_W-1:0] r_now;
    logic [ttm_pkg::PID_W-1:0]  r_owner;
    logic                       r_late;
    logic [ttm_pkg::TICK_W-1:0] r_diff;

    // Result being built, and the output register.
    logic [ttm_pkg::ACT_W-1:0]  r_res_action;
    logic [ttm_pkg::FREQ_W-1:0] r_res_tone;
    logic [ttm_pkg::STAT_W-1:0] r_res_gt;
    logic [ttm_pkg::STAT_W-1:0] r_res_gs;
    logic [ttm_pkg::ACT_W-1:0]  r_out_action;
    logic [ttm_pkg::FREQ_W-1:0] r_out_tone;
    logic [ttm_pkg::PLAY_W-1:0] r_out_play;
    logic [ttm_pkg::STAT_W-1:0] r_out_gt;
    logic [ttm_pkg::STAT_W-1:0] r_out_gs;

    logic [EW-1:0]              in_ch_ext;
    logic [EW-1:0]              ch_ext;
    logic                       ch_ok;
    logic                       slot_nz;
    logic                       scan_hit;
    logic                       last_idx;
    logic                       on_current;
    logic                       note_on;
    logic [ttm_pkg::SLOT_W-1:0] reload;
    logic [ttm_pkg::FREQ_W-1:0] lfsr_step;
    logic [ttm_pkg::FREQ_W-1:0] noise_tone;

    assign in_ch_ext  = EW'(i_channel);
    assign ch_ext     = EW'(r_channel);
    assign ch_ok      = (ch_ext < EW'(CHANNELS));
    assign slot_nz    = (r_slot_left != '0);
    assign scan_hit   = r_chan_active[r_rotor];
    assign last_idx   = (r_idx == LAST);
    assign on_current = (r_idx == r_current);
    assign note_on    = (r_cmd == ttm_pkg::CMD_NOTE) && (r_freq != '0);
    // A slot length of zero behaves as one.
    assign reload     = (r_slot_length == '0) ? '0 : r_slot_length - 1'b1;
    assign lfsr_step  = ttm_pkg::lfsr_next(r_lfsr);
    assign noise_tone = ttm_pkg::NOISE_BASE + (lfsr_step & ttm_pkg::NOISE_MASK);

    assign o_status.cmd       = r_cmd;
    assign o_status.ch_ok     = ch_ok;
    assign o_status.pid_match = (r_pid == r_owner);
    assign o_status.slot_nz   = slot_nz;
    assign o_status.scan_hit  = scan_hit;
    assign o_status.last_idx  = last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_chan_freq[i]     <= '0;
                r_chan_active[i]   <= 1'b0;
                r_chan_deadline[i] <= '0;
                r_chan_dl_valid[i] <= 1'b0;
                r_chan_glitches[i] <= '0;
                r_chan_delay[i]    <= '0;
            end
            r_rotor       <= '0;
            r_current     <= '0;
            r_idx         <= '0;
            r_slot_left   <= '0;
            r_slot_length <= ttm_pkg::SLOT_RESET;
            r_lfsr        <= ttm_pkg::LFSR_SEED;
            r_now         <= '0;
            r_owner       <= '0;
            r_late        <= 1'b0;
            r_diff        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_slot_length <= i_cfg_data;
            end
            if (i_ctrl.load) begin
                r_idx <= in_ch_ext[CW-1:0];
            end else if (i_ctrl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctrl.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_ctrl.tick) begin
                r_now <= r_now + 1'b1;
                if (slot_nz) begin
                    r_slot_left <= r_slot_left - 1'b1;
                end
            end
            if (i_ctrl.scan) begin
                r_rotor <= (r_rotor == LAST) ? '0 : r_rotor + 1'b1;
                if (scan_hit) begin
                    r_current   <= r_rotor;
                    r_slot_left <= reload;
                    if (r_rotor == LAST) begin
                        r_lfsr <= lfsr_step;
                    end
                end
            end
            if (i_ctrl.check) begin
                r_late <= r_chan_dl_valid[r_idx] && (r_now > r_chan_deadline[r_idx]);
                r_diff <= r_now - r_chan_deadline[r_idx];
            end
            if (i_ctrl.apply) begin
                if (r_late) begin
                    r_chan_glitches[r_idx] <= r_chan_glitches[r_idx] + 1'b1;
                    r_chan_delay[r_idx]    <= r_chan_delay[r_idx] + r_diff;
                end
                if (note_on) begin
                    r_chan_freq[r_idx]     <= r_freq;
                    r_chan_active[r_idx]   <= 1'b1;
                    r_chan_dl_valid[r_idx] <= (r_dl != '0);
                    r_chan_deadline[r_idx] <= (r_dl != '0)
                        ? r_now + ttm_pkg::TICK_W'(r_dl) : '0;
                end else begin
                    r_chan_freq[r_idx]     <= '0;
                    r_chan_active[r_idx]   <= 1'b0;
                    r_chan_dl_valid[r_idx] <= 1'b0;
                    r_chan_deadline[r_idx] <= '0;
                    if (on_current) begin
                        r_slot_left <= '0;
                    end
                end
                if (r_cmd == ttm_pkg::CMD_NOTE) begin
                    r_owner <= r_pid;
                end else if (last_idx) begin
                    r_owner <= '0;
                end
            end
            if (i_ctrl.clr_stats) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_chan_glitches[i] <= '0;
                    r_chan_delay[i]    <= '0;
                    r_chan_deadline[i] <= '0;
                    r_chan_dl_valid[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd        <= i_cmd;
            r_channel    <= i_channel;
            r_freq       <= i_freq_hz;
            r_dl         <= i_deadline_ms;
            r_pid        <= i_task_pid;
            r_res_action <= ttm_pkg::ACT_NONE;
            r_res_tone   <= '0;
            r_res_gt     <= '0;
            r_res_gs     <= '0;
        end
        if (i_ctrl.tick && !slot_nz) begin
            r_res_action <= ttm_pkg::ACT_STOP;
        end
        if (i_ctrl.scan && scan_hit) begin
            r_res_action <= ttm_pkg::ACT_TONE;
            r_res_tone   <= (r_rotor == LAST) ? noise_tone : r_chan_freq[r_rotor];
        end
        // A new note on the channel that holds the slot is played at once.
        if (i_ctrl.apply && note_on && on_current && slot_nz) begin
            r_res_action <= ttm_pkg::ACT_TONE;
            r_res_tone   <= r_freq;
        end
        if (i_ctrl.read && ch_ok) begin
            r_res_gt <= r_chan_glitches[r_idx];
            r_res_gs <= r_chan_delay[r_idx];
        end
        if (i_ctrl.emit) begin
            r_out_action <= r_res_action;
            r_out_tone   <= r_res_tone;
            r_out_play   <= ttm_pkg::PLAY_W'(r_current);
            r_out_gt     <= r_res_gt;
            r_out_gs     <= r_res_gs;
        end
    end

    assign o_action           = r_out_action;
    assign o_tone_hz          = r_out_tone;
    assign o_playing_channel  = r_out_play;
    assign o_glitch_total     = r_out_gt;
    assign o_glitch_delay_sum = r_out_gs;

endmodule

@@ src/tdm_tone_channel_multiplexer.sv @@
// Top level of the time-division tone multiplexer: controller plus datapath.
// Depends on ttm_pkg, ttm_ctrl and ttm_datapath.
//
// Usage: every input word (tick, note, stats reset, task exit, stats read) on
// i_in_valid / o_in_stall yields exactly one output word on o_out_valid /
// i_out_stall. A word is taken when valid is high and stall is low on a rising
// clock edge. The slot length register is written through i_cfg_valid /
// o_cfg_ready, which is always ready; write it only while the block is idle.
// From acceptance to o_out_valid: a tick inside a running slot, stats reset,
// stats read, ignored words and a note on a bad channel go from decode straight
// to the result state; a tick that ends a slot scans one channel per cycle, up
// to CHANNELS channels; a note goes through check and apply; a task exit that
// matches the owner checks and stops each channel in turn. The controller
// handles one word at a time and goes back to idle after each result before it
// accepts the next word.
// The output register lets the block take the next word while a result waits;
// a stalled receiver holds the result, and a further result then waits inside.
// Reset (synchronous, active low) clears all channels and statistics, sets the
// slot length to 20 and seeds the noise register; the block is ready at once.
module tdm_tone_channel_multiplexer #(
    parameter int CHANNELS = ttm_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ttm_pkg::SLOT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ttm_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ttm_pkg::CHAN_W-1:0]  i_channel,
    input  logic [ttm_pkg::FREQ_W-1:0]  i_freq_hz,
    input  logic [ttm_pkg::DL_W-1:0]    i_deadline_ms,
    input  logic [ttm_pkg::PID_W-1:0]   i_task_pid,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ttm_pkg::ACT_W-1:0]   o_action,
    output logic [ttm_pkg::FREQ_W-1:0]  o_tone_hz,
    output logic [ttm_pkg::PLAY_W-1:0]  o_playing_channel,
    output logic [ttm_pkg::STAT_W-1:0]  o_glitch_total,
    output logic [ttm_pkg::STAT_W-1:0]  o_glitch_delay_sum
);

    ttm_pkg::t_ctrl   ctl;
    ttm_pkg::t_status st;

    assign o_cfg_ready = 1'b1;

    ttm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (st),
        .o_ctrl      (ctl)
    );

    ttm_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (ctl),
        .o_status           (st),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (i_cmd),
        .i_channel          (i_channel),
        .i_freq_hz          (i_freq_hz),
        .i_deadline_ms      (i_deadline_ms),
        .i_task_pid         (i_task_pid),
        .o_action           (o_action),
        .o_tone_hz          (o_tone_hz),
        .o_playing_channel  (o_playing_channel),
        .o_glitch_total     (o_glitch_total),
        .o_glitch_delay_sum (o_glitch_delay_sum)
    );

endmodule
